### rtl/agfr_pkg.sv
// shared types and constants for the audio gain fade ramp block
`default_nettype none

package agfr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int TGT_W       = 16;
    localparam int MS_W        = 16;
    localparam int FPM_W       = 8;
    localparam int FRAMES_W    = 24;
    localparam int DIVISOR_W   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FPM_W-1:0] FPM_RESET = 8'd48;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_FADE   = 2'd1,
        OP_STOP   = 2'd2,
        OP_START  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_adv;
        logic [TGT_W-1:0]           target;
        logic                       fade_kind;
        logic [MS_W-1:0]            fade_ms;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCALE,
        ST_SCALE_WAIT,
        ST_CNT,
        ST_CNT_WAIT,
        ST_OFS_MUL,
        ST_OFS_DIV,
        ST_OFS_WAIT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

### rtl/agfr_front.sv
// input side: accepts transfers, classifies them and queues them for the core
`default_nettype none

module agfr_front
    import agfr_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 cmd,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       frame_end,
    input  wire logic [TGT_W-1:0]           target_level,
    input  wire logic                       fade_kind,
    input  wire logic [MS_W-1:0]            fade_ms,
    output logic                            item_valid,
    output item_t                           item,
    input  wire logic                       pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    item_t            new_item;

    assign in_stall   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign item_valid = (count_reg != '0);
    assign item       = queue_reg[rd_ptr_reg];

    // classify
    always_comb
    begin
        new_item.op        = op_t'(cmd);
        new_item.sample    = sample;
        new_item.frame_adv = (op_t'(cmd) == OP_SAMPLE) && frame_end;
        new_item.target    = target_level;
        new_item.fade_kind = fade_kind;
        new_item.fade_ms   = fade_ms;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

`default_nettype wire

### rtl/agfr_div.sv
// unsigned restoring divider, one quotient bit per cycle
`default_nettype none

module agfr_div #(
    parameter int DVD_W = 27,
    parameter int DSR_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] rem_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] dsr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [DSR_W:0]   rem_sh;
    logic [DSR_W:0]   trial;

    assign rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
    assign trial    = rem_sh - {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DSR_W])
            begin
                rem_next = trial[DSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg == CNT_W'(1) |=> done_reg && !busy_reg)
        else $error("divider did not finish after last step");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

### rtl/agfr_core.sv
// back end: track state, sample scaling and linear fade sequencer
`default_nettype none

module agfr_core
    import agfr_pkg::*;
#(
    parameter int UNIT_GAIN = 256,
    parameter int MAX_GAIN  = 1024,
    parameter int LW        = 11
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wen,
    input  wire logic [FPM_W-1:0]    cfg_wdata,
    input  wire logic                item_valid,
    input  wire item_t               item,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     accepted,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic [LW-1:0]            current_level,
    output logic                     running
);

    localparam int PROD_W = LW + 18;
    localparam int DVD_W  = (LW + 16 > FRAMES_W) ? LW + 16 : FRAMES_W;
    // reciprocal of the unit gain, exact for magnitudes below 2**SCL_N
    localparam int SCL_N  = LW + 15;
    localparam int SCL_L  = $clog2(UNIT_GAIN);
    localparam int SCL_W  = 2 * SCL_N + 1;
    localparam logic [63:0] SCL_RECIP =
        ((64'd1 << (SCL_N + SCL_L)) + 64'(UNIT_GAIN) - 64'd1) / 64'(UNIT_GAIN);

    state_t                state_reg;
    state_t                state_next;
    logic                  playing_reg;
    logic                  playing_next;
    logic                  stopping_reg;
    logic                  stopping_next;
    logic                  fading_reg;
    logic                  fading_next;
    logic [LW-1:0]         level_now_reg;
    logic [LW-1:0]         level_now_next;
    logic [LW-1:0]         level_start_reg;
    logic [LW-1:0]         level_start_next;
    logic [LW-1:0]         level_goal_reg;
    logic [LW-1:0]         level_goal_next;
    logic [MS_W-1:0]       len_ms_reg;
    logic [MS_W-1:0]       len_ms_next;
    logic [FRAMES_W-1:0]   len_frames_reg;
    logic [FRAMES_W-1:0]   len_frames_next;
    logic [FRAMES_W-1:0]   count_reg;
    logic [FRAMES_W-1:0]   count_next;
    logic [FPM_W-1:0]      fpm_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    item_t                 item_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [SCL_W-1:0]      scl_reg;
    logic [SCL_W-1:0]      scl_next;
    logic [MS_W-1:0]       elapsed_reg;
    logic [MS_W-1:0]       elapsed_next;
    logic                  res_acc_reg;
    logic                  res_acc_next;
    logic [SAMPLE_W-1:0]   res_sout_reg;
    logic [SAMPLE_W-1:0]   res_sout_next;
    logic                  out_acc_reg;
    logic [SAMPLE_W-1:0]   out_sout_reg;
    logic [LW-1:0]         out_level_reg;
    logic                  out_run_reg;

    logic                  div_start;
    logic [DVD_W-1:0]      div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DVD_W-1:0]      div_quo;
    logic                  emit;

    logic [FPM_W-1:0]      fpm_eff;
    logic [PROD_W-1:0]     prod_mag;
    logic [SCL_W-1:0]      scl_quo;
    logic signed [16:0]    mul_x;
    logic signed [LW:0]    mul_y;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [LW:0]    diff;
    logic [LW-1:0]         tgt_sat;
    logic [LW-1:0]         arm_tgt;
    logic [LW-1:0]         arm_base;
    logic [LW-1:0]         fin_level;

    assign fpm_eff  = (fpm_reg == '0) ? FPM_W'(1) : fpm_reg;
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign scl_quo  = scl_reg >> (SCL_N + SCL_L);
    assign diff     = $signed({1'b0, level_goal_reg}) - $signed({1'b0, level_start_reg});
    assign tgt_sat  = ({1'b0, item_reg.target} > 17'(MAX_GAIN)) ? LW'(MAX_GAIN)
                                                                  : item_reg.target[LW-1:0];
    assign arm_tgt  = (item_reg.op == OP_STOP) ? '0 : tgt_sat;
    assign arm_base = (item_reg.op == OP_START) ? '0 : level_now_reg;
    assign fin_level = stopping_reg ? '0 : level_goal_reg;

    // one shared multiplier: sample by level, or level span by elapsed time
    always_comb
    begin
        if (state_reg == ST_OFS_MUL)
        begin
            mul_x = $signed({1'b0, elapsed_reg});
            mul_y = diff;
        end
        else
        begin
            mul_x = 17'(item_reg.sample);
            mul_y = $signed({1'b0, level_now_reg});
        end
    end

    assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

    agfr_div #(
        .DVD_W (DVD_W),
        .DSR_W (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (item_reg.op == OP_SAMPLE && playing_reg)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_SCALE_WAIT;
            end
            ST_SCALE_WAIT:
            begin
                if (item_reg.frame_adv && fading_reg && count_reg != len_frames_reg)
                begin
                    state_next = ST_CNT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_CNT:
            begin
                state_next = ST_CNT_WAIT;
            end
            ST_CNT_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (len_ms_reg == '0) ? ST_EMIT : ST_OFS_MUL;
                end
            end
            ST_OFS_MUL:
            begin
                state_next = ST_OFS_DIV;
            end
            ST_OFS_DIV:
            begin
                state_next = ST_OFS_WAIT;
            end
            ST_OFS_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = DVD_W'(prod_mag);
        div_divisor  = len_ms_reg;
        emit         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop = item_valid;
            end
            ST_CNT:
            begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(count_reg);
                div_divisor  = DIVISOR_W'(fpm_eff);
            end
            ST_OFS_DIV:
            begin
                div_start   = 1'b1;
                div_divisor = len_ms_reg;
            end
            ST_EMIT:
            begin
                emit = !out_valid_reg || !out_stall;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        playing_next     = playing_reg;
        stopping_next    = stopping_reg;
        fading_next      = fading_reg;
        level_now_next   = level_now_reg;
        level_start_next = level_start_reg;
        level_goal_next  = level_goal_reg;
        len_ms_next      = len_ms_reg;
        len_frames_next  = len_frames_reg;
        count_next       = count_reg;
        prod_next        = prod_reg;
        scl_next         = scl_reg;
        elapsed_next     = elapsed_reg;
        res_acc_next     = res_acc_reg;
        res_sout_next    = res_sout_reg;
        case (state_reg)
            ST_DECODE:
            begin
                res_sout_next = '0;
                res_acc_next  = (item_reg.op == OP_START) || playing_reg;
                if (item_reg.op == OP_SAMPLE)
                begin
                    prod_next = mul_p;
                end
                else if (playing_reg || item_reg.op == OP_START)
                begin
                    fading_next = item_reg.fade_kind;
                    count_next  = '0;
                    if (item_reg.fade_kind)
                    begin
                        len_ms_next      = item_reg.fade_ms;
                        len_frames_next  = FRAMES_W'(item_reg.fade_ms) * FRAMES_W'(fpm_eff);
                        level_start_next = arm_base;
                        level_now_next   = arm_base;
                        level_goal_next  = arm_tgt;
                    end
                    else
                    begin
                        len_ms_next      = '0;
                        len_frames_next  = '0;
                        level_start_next = arm_tgt;
                        level_now_next   = arm_tgt;
                        level_goal_next  = arm_tgt;
                    end
                    if (item_reg.op == OP_STOP)
                    begin
                        stopping_next = item_reg.fade_kind;
                        playing_next  = item_reg.fade_kind;
                    end
                    if (item_reg.op == OP_START)
                    begin
                        stopping_next = 1'b0;
                        playing_next  = 1'b1;
                    end
                end
            end
            ST_SCALE:
            begin
                // divide by the unit gain as a multiply by its reciprocal
                scl_next = SCL_W'(prod_mag[SCL_N-1:0]) * SCL_W'(SCL_RECIP[SCL_N:0]);
            end
            ST_SCALE_WAIT:
            begin
                res_sout_next = prod_reg[PROD_W-1] ? SAMPLE_W'(0) - scl_quo[SAMPLE_W-1:0]
                                                   : scl_quo[SAMPLE_W-1:0];
                if (item_reg.frame_adv && fading_reg)
                begin
                    if (count_reg == len_frames_reg)
                    begin
                        // fade finished, a pending stop ends the track
                        fading_next      = 1'b0;
                        count_next       = '0;
                        len_ms_next      = '0;
                        len_frames_next  = '0;
                        level_start_next = fin_level;
                        level_now_next   = fin_level;
                        level_goal_next  = fin_level;
                        if (stopping_reg)
                        begin
                            stopping_next = 1'b0;
                            playing_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_CNT_WAIT:
            begin
                if (div_done)
                begin
                    elapsed_next = (div_quo > DVD_W'(len_ms_reg)) ? len_ms_reg
                                                                  : div_quo[MS_W-1:0];
                end
            end
            ST_OFS_MUL:
            begin
                prod_next = mul_p;
            end
            ST_OFS_WAIT:
            begin
                if (div_done)
                begin
                    level_now_next = prod_reg[PROD_W-1] ? level_start_reg - div_quo[LW-1:0]
                                                        : level_start_reg + div_quo[LW-1:0];
                end
            end
            default:
            begin
                res_acc_next = res_acc_reg;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            playing_reg     <= 1'b0;
            stopping_reg    <= 1'b0;
            fading_reg      <= 1'b0;
            level_now_reg   <= '0;
            level_start_reg <= '0;
            level_goal_reg  <= '0;
            len_ms_reg      <= '0;
            len_frames_reg  <= '0;
            count_reg       <= '0;
            fpm_reg         <= FPM_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            playing_reg     <= playing_next;
            stopping_reg    <= stopping_next;
            fading_reg      <= fading_next;
            level_now_reg   <= level_now_next;
            level_start_reg <= level_start_next;
            level_goal_reg  <= level_goal_next;
            len_ms_reg      <= len_ms_next;
            len_frames_reg  <= len_frames_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wen)
            begin
                fpm_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item;
        end
        prod_reg     <= prod_next;
        scl_reg      <= scl_next;
        elapsed_reg  <= elapsed_next;
        res_acc_reg  <= res_acc_next;
        res_sout_reg <= res_sout_next;
        if (emit)
        begin
            out_acc_reg   <= res_acc_reg;
            out_sout_reg  <= res_sout_reg;
            out_level_reg <= level_now_reg;
            out_run_reg   <= playing_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = out_acc_reg;
    assign sample_out    = $signed(out_sout_reg);
    assign current_level = out_level_reg;
    assign running       = out_run_reg;

    a_fade_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
        fading_reg |-> playing_reg)
        else $error("fade active while track stopped");

    a_stop_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
        stopping_reg |-> playing_reg)
        else $error("stop pending while track stopped");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_now_reg <= LW'(MAX_GAIN))
        else $error("level above maximum");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= len_frames_reg)
        else $error("frame count past fade length");

endmodule

`default_nettype wire

### rtl/audio_gain_fade_ramp_top.sv
// top level of the audio gain fade ramp block
// Scales signed 16-bit PCM samples by level / UNIT_GAIN (truncated toward zero, wrapped
// to 16 bits) while a track plays, and runs a linear fade that advances on each
// frame-end sample. A two-entry input queue takes transfers while the core works on one
// item at a time; one result is returned per item. The division by UNIT_GAIN is done as
// a multiply by its reciprocal. A frame-end sample during a fade adds two passes of a
// shared divider with a dividend of DVD_W = max(level width + 16, 24) bits that produces
// one quotient bit per cycle (frames to ms, then the level interpolation). A stalled
// result holds the core until it is taken. frames_per_ms is written through cfg_wen /
// cfg_wdata.
`default_nettype none

module audio_gain_fade_ramp_top
    import agfr_pkg::*;
#(
    parameter int UNIT_GAIN = 256,
    parameter int MAX_GAIN  = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wen,
    input  wire logic [FPM_W-1:0]           cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 cmd,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       frame_end,
    input  wire logic [TGT_W-1:0]           target_level,
    input  wire logic                       fade_kind,
    input  wire logic [MS_W-1:0]            fade_ms,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            accepted,
    output logic signed [SAMPLE_W-1:0]      sample_out,
    output logic [$clog2(MAX_GAIN + 1)-1:0] current_level,
    output logic                            running
);

    localparam int LW = $clog2(MAX_GAIN + 1);

    logic  item_valid;
    item_t item;
    logic  pop;

    agfr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .sample       (sample),
        .frame_end    (frame_end),
        .target_level (target_level),
        .fade_kind    (fade_kind),
        .fade_ms      (fade_ms),
        .item_valid   (item_valid),
        .item         (item),
        .pop          (pop)
    );

    agfr_core #(
        .UNIT_GAIN (UNIT_GAIN),
        .MAX_GAIN  (MAX_GAIN),
        .LW        (LW)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .item_valid    (item_valid),
        .item          (item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .accepted      (accepted),
        .sample_out    (sample_out),
        .current_level (current_level),
        .running       (running)
    );

endmodule

`default_nettype wire
